// ----- sv/rotation_matrix_to_quaternion_macros.svh -----
// assertion macros for the rotation matrix to quaternion block
`ifndef ROTATION_MATRIX_TO_QUATERNION_MACROS_SVH
`define ROTATION_MATRIX_TO_QUATERNION_MACROS_SVH

`ifndef SYNTH

// same-cycle implication under reset
`define RMQ_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rmq assertion failed");

// next-cycle implication under reset
`define RMQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rmq assertion failed");

`else

`define RMQ_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define RMQ_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ----- sv/rmq_pkg.sv -----
// package with widths, types and helpers for the rotation matrix to quaternion block
`default_nettype none

package rmq_pkg;

    localparam int DATA_WIDTH = 16;
    localparam int FRAC       = DATA_WIDTH - 2;
    // radicand width, a << FRAC
    localparam int VW         = 2 * DATA_WIDTH;
    // square root remainder width
    localparam int SQW        = DATA_WIDTH + 2;
    // numerator magnitude width
    localparam int NW         = DATA_WIDTH + 1;
    // dividend and quotient width
    localparam int DW         = 2 * DATA_WIDTH - 1;
    // divider remainder width
    localparam int DRW        = DATA_WIDTH + 2;
    // divisor width, 2 * root
    localparam int DENW       = DATA_WIDTH + 1;
    localparam int NUM_LANES  = 3;
    // input register + root cells + prep register + divide cells + output register
    localparam int LAT        = DATA_WIDTH + DW + 3;

    typedef logic signed [DATA_WIDTH-1:0] fix_t;

    typedef enum logic [1:0] {
        BR_TRACE = 2'd0,
        BR_X     = 2'd1,
        BR_Y     = 2'd2,
        BR_Z     = 2'd3
    } branch_t;

    typedef struct packed {
        fix_t r00;
        fix_t r01;
        fix_t r02;
        fix_t r10;
        fix_t r11;
        fix_t r12;
        fix_t r20;
        fix_t r21;
        fix_t r22;
    } matrix_t;

    typedef struct packed {
        fix_t       quat_w;
        fix_t       quat_x;
        fix_t       quat_y;
        fix_t       quat_z;
        logic [1:0] branch_taken;
    } quat_t;

    // word riding along the root cells
    typedef struct packed {
        branch_t                         br;
        logic                            apos;
        logic [NUM_LANES-1:0]            neg;
        logic [NUM_LANES-1:0][NW-1:0]    mag;
    } sq_side_t;

    // word riding along the divide cells
    typedef struct packed {
        branch_t              br;
        logic                 apos;
        logic [NUM_LANES-1:0] neg;
        fix_t                 own;
    } dv_side_t;

    // signed quotient with saturation to the field range
    function automatic fix_t sat_quo(input logic neg, input logic [DW-1:0] q);
        logic [DW-1:0] pos_max;
        logic [DW-1:0] neg_max;
        fix_t          res;
        pos_max = DW'((64'd1 << (DATA_WIDTH - 1)) - 64'd1);
        neg_max = DW'(64'd1 << (DATA_WIDTH - 1));
        if (!neg)
        begin
            if (q > pos_max)
                res = fix_t'(pos_max[DATA_WIDTH-1:0]);
            else
                res = fix_t'(q[DATA_WIDTH-1:0]);
        end
        else
        begin
            if (q > neg_max)
                res = fix_t'(neg_max[DATA_WIDTH-1:0]);
            else
                res = fix_t'(-q[DATA_WIDTH-1:0]);
        end
        return res;
    endfunction

endpackage

`default_nettype wire

// ----- sv/rmq_sqrt_cell.sv -----
// one cell of the square root chain, one root bit per cell
`default_nettype none

module rmq_sqrt_cell (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          valid_in,
    input  wire logic [rmq_pkg::VW-1:0]        rad_in,
    input  wire logic [rmq_pkg::SQW-1:0]       rem_in,
    input  wire logic [rmq_pkg::DATA_WIDTH-1:0] root_in,
    input  wire rmq_pkg::sq_side_t             side_in,
    output logic                               valid_out,
    output logic [rmq_pkg::VW-1:0]             rad_out,
    output logic [rmq_pkg::SQW-1:0]            rem_out,
    output logic [rmq_pkg::DATA_WIDTH-1:0]     root_out,
    output rmq_pkg::sq_side_t                  side_out
);
    import rmq_pkg::*;

    logic [SQW+1:0]        trial_rem;
    logic [SQW+1:0]        trial;
    logic                  ge;
    logic [SQW-1:0]        rem_next;
    logic [DATA_WIDTH-1:0] root_next;
    logic [VW-1:0]         rad_next;
    logic                  valid_reg;
    logic [VW-1:0]         rad_reg;
    logic [SQW-1:0]        rem_reg;
    logic [DATA_WIDTH-1:0] root_reg;
    sq_side_t              side_reg;

    // bring down the next two radicand bits and try root*4+1
    always_comb
    begin
        trial_rem = {rem_in, rad_in[VW-1:VW-2]};
        trial     = (SQW+2)'({root_in, 2'b01});
        ge        = (trial_rem >= trial);
        rem_next  = ge ? SQW'(trial_rem - trial) : SQW'(trial_rem);
        root_next = {root_in[DATA_WIDTH-2:0], ge};
        rad_next  = {rad_in[VW-3:0], 2'b00};
    end

    // valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_in;
    end

    // payload
    always_ff @(posedge clk)
    begin
        rad_reg  <= rad_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
        side_reg <= side_in;
    end

    assign valid_out = valid_reg;
    assign rad_out   = rad_reg;
    assign rem_out   = rem_reg;
    assign root_out  = root_reg;
    assign side_out  = side_reg;

endmodule

`default_nettype wire

// ----- sv/rmq_div_cell.sv -----
// one cell of the divide chain, one quotient bit per lane per cell
`default_nettype none

module rmq_div_cell (
    input  wire logic                                              clk,
    input  wire logic                                              rst_n,
    input  wire logic                                              valid_in,
    input  wire logic [rmq_pkg::DENW-1:0]                          den_in,
    input  wire logic [rmq_pkg::NUM_LANES-1:0][rmq_pkg::DRW-1:0]   rem_in,
    input  wire logic [rmq_pkg::NUM_LANES-1:0][rmq_pkg::DW-1:0]    quo_in,
    input  wire rmq_pkg::dv_side_t                                 side_in,
    output logic                                                   valid_out,
    output logic [rmq_pkg::DENW-1:0]                               den_out,
    output logic [rmq_pkg::NUM_LANES-1:0][rmq_pkg::DRW-1:0]        rem_out,
    output logic [rmq_pkg::NUM_LANES-1:0][rmq_pkg::DW-1:0]         quo_out,
    output rmq_pkg::dv_side_t                                      side_out
);
    import rmq_pkg::*;

    logic [NUM_LANES-1:0][DRW-1:0] part;
    logic [NUM_LANES-1:0]          ge;
    logic [NUM_LANES-1:0][DRW-1:0] rem_next;
    logic [NUM_LANES-1:0][DW-1:0]  quo_next;
    logic [DRW-1:0]                den_ext;
    logic                          valid_reg;
    logic [DENW-1:0]               den_reg;
    logic [NUM_LANES-1:0][DRW-1:0] rem_reg;
    logic [NUM_LANES-1:0][DW-1:0]  quo_reg;
    dv_side_t                      side_reg;

    // restoring step: dividend shifts out on top, quotient bit enters at bottom
    always_comb
    begin
        den_ext = DRW'(den_in);
        for (int l = 0; l < NUM_LANES; l++)
        begin
            part[l]     = {rem_in[l][DRW-2:0], quo_in[l][DW-1]};
            ge[l]       = (part[l] >= den_ext);
            rem_next[l] = ge[l] ? DRW'(part[l] - den_ext) : part[l];
            quo_next[l] = {quo_in[l][DW-2:0], ge[l]};
        end
    end

    // valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_in;
    end

    // payload
    always_ff @(posedge clk)
    begin
        den_reg  <= den_in;
        rem_reg  <= rem_next;
        quo_reg  <= quo_next;
        side_reg <= side_in;
    end

    assign valid_out = valid_reg;
    assign den_out   = den_reg;
    assign rem_out   = rem_reg;
    assign quo_out   = quo_reg;
    assign side_out  = side_reg;

endmodule

`default_nettype wire

// ----- sv/rotation_matrix_to_quaternion.sv -----
// top level: rotation matrix to unit quaternion, Shepperd's method, fully pipelined
//
// Usage:
//   Drive the nine Q2.14 matrix entries on matrix and raise start for one
//   cycle per word. busy is held low, so a word is taken on every clock
//   edge at which start is high; words may follow each other back to back.
//   Each word yields one result word on result, marked by done for exactly
//   one cycle; the word passes through the input register, the root cells,
//   the prep register, the divide cells and the output register on its way
//   there. Results leave in the order the words came in.
//   Throughput is one word per cycle: the square root is a row of
//   DATA_WIDTH cells, one root bit each, and the three divisions share a
//   row of 2*DATA_WIDTH-1 cells, one quotient bit per lane each.
//   The receiver cannot stall: result is valid only in the done cycle.
//   Reset clears the valid flags of every stage, so no word is in flight
//   afterwards and done stays low until a new word has passed through.
//   A non-positive root argument gives zero quaternion fields while
//   branch_taken still reports the chosen branch.
`default_nettype none

`include "rotation_matrix_to_quaternion_macros.svh"

module rotation_matrix_to_quaternion (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    output logic                  busy,
    input  wire rmq_pkg::matrix_t matrix,
    output logic                  done,
    output rmq_pkg::quat_t        result
);
    import rmq_pkg::*;

    localparam int AW = DATA_WIDTH + 3;

    // input stage
    logic signed [AW-1:0]          m00, m01, m02, m10, m11, m12, m20, m21, m22;
    logic signed [AW-1:0]          one_c;
    logic signed [AW-1:0]          tr;
    logic signed [AW-1:0]          a_val;
    branch_t                       br_sel;
    logic signed [AW-1:0]          n0, n1, n2;
    logic signed [AW-1:0]          n_sel [NUM_LANES];
    sq_side_t                      s0_side_next;
    logic [VW-1:0]                 s0_rad_next;

    // root chain taps
    logic                          sq_valid [DATA_WIDTH+1];
    logic [VW-1:0]                 sq_rad   [DATA_WIDTH+1];
    logic [SQW-1:0]                sq_rem   [DATA_WIDTH+1];
    logic [DATA_WIDTH-1:0]         sq_root  [DATA_WIDTH+1];
    sq_side_t                      sq_side  [DATA_WIDTH+1];

    // prep stage
    logic [DATA_WIDTH-1:0]         rt;
    logic [DATA_WIDTH:0]           rt_inc;
    fix_t                          own_val;
    logic [NUM_LANES-1:0][DW-1:0]  dvd_next;
    dv_side_t                      dv_side_next;

    // divide chain taps
    logic                          dv_valid [DW+1];
    logic [DENW-1:0]               dv_den   [DW+1];
    logic [NUM_LANES-1:0][DRW-1:0] dv_rem   [DW+1];
    logic [NUM_LANES-1:0][DW-1:0]  dv_quo   [DW+1];
    dv_side_t                      dv_side  [DW+1];

    // output stage
    fix_t                          d0, d1, d2;
    quat_t                         result_next;
    logic                          done_reg;
    quat_t                         result_reg;

    assign busy = 1'b0;

    // trace, branch choice, root argument and the three numerators
    always_comb
    begin
        m00   = AW'(matrix.r00);
        m01   = AW'(matrix.r01);
        m02   = AW'(matrix.r02);
        m10   = AW'(matrix.r10);
        m11   = AW'(matrix.r11);
        m12   = AW'(matrix.r12);
        m20   = AW'(matrix.r20);
        m21   = AW'(matrix.r21);
        m22   = AW'(matrix.r22);
        one_c = AW'(64'd1 << FRAC);
        tr    = m00 + m11 + m22;
        priority if (tr > 0)
        begin
            br_sel = BR_TRACE;
            a_val  = tr + one_c;
            n0     = m21 - m12;
            n1     = m02 - m20;
            n2     = m10 - m01;
        end
        else if (m00 > m11 && m00 > m22)
        begin
            br_sel = BR_X;
            a_val  = one_c + m00 - m11 - m22;
            n0     = m21 - m12;
            n1     = m01 + m10;
            n2     = m02 + m20;
        end
        else if (m11 > m22)
        begin
            br_sel = BR_Y;
            a_val  = one_c + m11 - m00 - m22;
            n0     = m02 - m20;
            n1     = m01 + m10;
            n2     = m12 + m21;
        end
        else
        begin
            br_sel = BR_Z;
            a_val  = one_c + m22 - m00 - m11;
            n0     = m10 - m01;
            n1     = m02 + m20;
            n2     = m12 + m21;
        end
        n_sel[0] = n0;
        n_sel[1] = n1;
        n_sel[2] = n2;
        s0_side_next.br   = br_sel;
        s0_side_next.apos = (a_val > 0);
        for (int l = 0; l < NUM_LANES; l++)
        begin
            s0_side_next.neg[l] = n_sel[l][AW-1];
            s0_side_next.mag[l] = n_sel[l][AW-1] ? NW'(-n_sel[l]) : NW'(n_sel[l]);
        end
        s0_rad_next = VW'({a_val[DATA_WIDTH:0], {FRAC{1'b0}}});
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sq_valid[0] <= 1'b0;
        else
            sq_valid[0] <= start && !busy;
    end

    always_ff @(posedge clk)
    begin
        sq_rad[0]  <= s0_rad_next;
        sq_side[0] <= s0_side_next;
    end

    assign sq_rem[0]  = '0;
    assign sq_root[0] = '0;

    // square root chain
    for (genvar i = 0; i < DATA_WIDTH; i++)
    begin : g_sqrt
        rmq_sqrt_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .valid_in  (sq_valid[i]),
            .rad_in    (sq_rad[i]),
            .rem_in    (sq_rem[i]),
            .root_in   (sq_root[i]),
            .side_in   (sq_side[i]),
            .valid_out (sq_valid[i+1]),
            .rad_out   (sq_rad[i+1]),
            .rem_out   (sq_rem[i+1]),
            .root_out  (sq_root[i+1]),
            .side_out  (sq_side[i+1])
        );
    end

    // own component and rounded dividends
    always_comb
    begin
        rt     = sq_root[DATA_WIDTH];
        rt_inc = (DATA_WIDTH+1)'(rt) + (DATA_WIDTH+1)'(1);
        if (rt_inc[DATA_WIDTH])
            own_val = fix_t'((64'd1 << (DATA_WIDTH - 1)) - 64'd1);
        else
            own_val = fix_t'(rt_inc[DATA_WIDTH:1]);
        for (int l = 0; l < NUM_LANES; l++)
            dvd_next[l] = DW'({sq_side[DATA_WIDTH].mag[l], {FRAC{1'b0}}}) + DW'(rt);
        dv_side_next.br   = sq_side[DATA_WIDTH].br;
        dv_side_next.apos = sq_side[DATA_WIDTH].apos;
        dv_side_next.neg  = sq_side[DATA_WIDTH].neg;
        dv_side_next.own  = own_val;
    end

    // prep register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            dv_valid[0] <= 1'b0;
        else
            dv_valid[0] <= sq_valid[DATA_WIDTH];
    end

    always_ff @(posedge clk)
    begin
        dv_den[0]  <= {rt, 1'b0};
        dv_quo[0]  <= dvd_next;
        dv_side[0] <= dv_side_next;
    end

    assign dv_rem[0] = '0;

    // divide chain
    for (genvar j = 0; j < DW; j++)
    begin : g_div
        rmq_div_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .valid_in  (dv_valid[j]),
            .den_in    (dv_den[j]),
            .rem_in    (dv_rem[j]),
            .quo_in    (dv_quo[j]),
            .side_in   (dv_side[j]),
            .valid_out (dv_valid[j+1]),
            .den_out   (dv_den[j+1]),
            .rem_out   (dv_rem[j+1]),
            .quo_out   (dv_quo[j+1]),
            .side_out  (dv_side[j+1])
        );
    end

    // sign, saturation and placement of the components by branch
    always_comb
    begin
        d0 = sat_quo(dv_side[DW].neg[0], dv_quo[DW][0]);
        d1 = sat_quo(dv_side[DW].neg[1], dv_quo[DW][1]);
        d2 = sat_quo(dv_side[DW].neg[2], dv_quo[DW][2]);
        result_next.branch_taken = dv_side[DW].br;
        unique case (dv_side[DW].br)
            BR_TRACE:
            begin
                result_next.quat_w = dv_side[DW].own;
                result_next.quat_x = d0;
                result_next.quat_y = d1;
                result_next.quat_z = d2;
            end
            BR_X:
            begin
                result_next.quat_w = d0;
                result_next.quat_x = dv_side[DW].own;
                result_next.quat_y = d1;
                result_next.quat_z = d2;
            end
            BR_Y:
            begin
                result_next.quat_w = d0;
                result_next.quat_x = d1;
                result_next.quat_y = dv_side[DW].own;
                result_next.quat_z = d2;
            end
            default:
            begin
                result_next.quat_w = d0;
                result_next.quat_x = d1;
                result_next.quat_y = d2;
                result_next.quat_z = dv_side[DW].own;
            end
        endcase
        if (!dv_side[DW].apos)
        begin
            result_next.quat_w = '0;
            result_next.quat_x = '0;
            result_next.quat_y = '0;
            result_next.quat_z = '0;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= dv_valid[DW];
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

    // checks
    `RMQ_ASSERT_IMPL(a_done_has_word, clk, rst_n, done, $past(start && !busy, LAT))
    `RMQ_ASSERT_NEXT(a_no_word_no_done, clk, rst_n, $past(!start, LAT - 1), !done)
    `RMQ_ASSERT_IMPL(a_trace_w_pos, clk, rst_n, done && result.branch_taken == BR_TRACE, !result.quat_w[DATA_WIDTH-1])
    `RMQ_ASSERT_IMPL(a_x_own_pos, clk, rst_n, done && result.branch_taken == BR_X, !result.quat_x[DATA_WIDTH-1])

endmodule

`default_nettype wire

// ----- sim/tb_rotation_matrix_to_quaternion.sv -----
// testbench for the rotation matrix to quaternion block
`timescale 1ns / 100ps

module tb_rotation_matrix_to_quaternion;

    import rmq_pkg::*;

    localparam int   N_RANDOM = 1300;
    localparam int   ONE_Q    = 1 << FRAC;
    localparam fix_t ONE_F    = fix_t'(ONE_Q);
    localparam int   MW       = $bits(matrix_t);

    logic    clk;
    logic    rst_n;
    logic    start;
    logic    busy;
    matrix_t matrix;
    logic    done;
    quat_t   result;

    rotation_matrix_to_quaternion u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .matrix (matrix),
        .done   (done),
        .result (result)
    );

    // saturate to the field range
    function automatic fix_t clamp_fix(input longint v);
        longint hi;
        longint lo;
        hi = (longint'(1) << (DATA_WIDTH - 1)) - 1;
        lo = -(longint'(1) << (DATA_WIDTH - 1));
        if (v > hi)
            return fix_t'(hi);
        if (v < lo)
            return fix_t'(lo);
        return fix_t'(v);
    endfunction

    // floor integer square root
    function automatic longint unsigned floor_sqrt(input longint unsigned v);
        longint unsigned res;
        longint unsigned b;
        res = 0;
        b = longint'(1) << 62;
        while (b > v)
            b = b >> 2;
        while (b != 0)
        begin
            if (v >= res + b)
            begin
                v = v - (res + b);
                res = (res >> 1) + b;
            end
            else
            begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    // numerator over 2*root, rounded half away from zero
    function automatic fix_t div_by_s(input longint n, input longint unsigned rt);
        longint unsigned mag;
        longint unsigned q;
        mag = (n < 0) ? longint'(-n) : longint'(n);
        q = ((mag << FRAC) + rt) / (rt * 2);
        return clamp_fix((n < 0) ? -longint'(q) : longint'(q));
    endfunction

    // expected quaternion for one matrix
    function automatic quat_t solve_quat(input matrix_t m);
        longint          e00, e01, e02, e10, e11, e12, e20, e21, e22;
        longint          tr;
        longint          rad;
        longint unsigned rt;
        fix_t            own;
        branch_t         br;
        quat_t           q;
        e00 = m.r00; e01 = m.r01; e02 = m.r02;
        e10 = m.r10; e11 = m.r11; e12 = m.r12;
        e20 = m.r20; e21 = m.r21; e22 = m.r22;
        tr = e00 + e11 + e22;
        if (tr > 0)
        begin
            br = BR_TRACE;
            rad = tr + ONE_Q;
        end
        else if (e00 > e11 && e00 > e22)
        begin
            br = BR_X;
            rad = ONE_Q + e00 - e11 - e22;
        end
        else if (e11 > e22)
        begin
            br = BR_Y;
            rad = ONE_Q + e11 - e00 - e22;
        end
        else
        begin
            br = BR_Z;
            rad = ONE_Q + e22 - e00 - e11;
        end
        q = '0;
        q.branch_taken = br;
        if (rad > 0)
        begin
            rt = floor_sqrt(longint'(rad) << FRAC);
            own = clamp_fix(longint'((rt + 1) >> 1));
            case (br)
                BR_TRACE:
                begin
                    q.quat_w = own;
                    q.quat_x = div_by_s(e21 - e12, rt);
                    q.quat_y = div_by_s(e02 - e20, rt);
                    q.quat_z = div_by_s(e10 - e01, rt);
                end
                BR_X:
                begin
                    q.quat_w = div_by_s(e21 - e12, rt);
                    q.quat_x = own;
                    q.quat_y = div_by_s(e01 + e10, rt);
                    q.quat_z = div_by_s(e02 + e20, rt);
                end
                BR_Y:
                begin
                    q.quat_w = div_by_s(e02 - e20, rt);
                    q.quat_x = div_by_s(e01 + e10, rt);
                    q.quat_y = own;
                    q.quat_z = div_by_s(e12 + e21, rt);
                end
                default:
                begin
                    q.quat_w = div_by_s(e10 - e01, rt);
                    q.quat_x = div_by_s(e02 + e20, rt);
                    q.quat_y = div_by_s(e12 + e21, rt);
                    q.quat_z = own;
                end
            endcase
        end
        return q;
    endfunction

    // random entry near a rotation range, sometimes full range
    function automatic fix_t rand_entry();
        if ($urandom_range(0, 7) == 0)
            return fix_t'($urandom);
        return fix_t'(int'($urandom_range(0, 2 * ONE_Q)) - ONE_Q);
    endfunction

    // random matrix: rotation-like entries, at times with a chosen dominant diagonal, at times fully random
    function automatic matrix_t rand_matrix();
        matrix_t m;
        int      pick;
        m = matrix_t'(MW'({$urandom, $urandom, $urandom, $urandom, $urandom}));
        if ($urandom_range(0, 9) == 0)
            return m;
        m.r00 = rand_entry(); m.r01 = rand_entry(); m.r02 = rand_entry();
        m.r10 = rand_entry(); m.r11 = rand_entry(); m.r12 = rand_entry();
        m.r20 = rand_entry(); m.r21 = rand_entry(); m.r22 = rand_entry();
        pick = $urandom_range(0, 4);
        // make one diagonal entry nonnegative and the other two nonpositive
        if (pick == 1)
        begin
            m.r11 = -fix_t'($urandom_range(0, ONE_Q));
            m.r22 = -fix_t'($urandom_range(0, ONE_Q));
            m.r00 = fix_t'($urandom_range(0, ONE_Q / 2));
        end
        else if (pick == 2)
        begin
            m.r00 = -fix_t'($urandom_range(0, ONE_Q));
            m.r22 = -fix_t'($urandom_range(0, ONE_Q));
            m.r11 = fix_t'($urandom_range(0, ONE_Q / 2));
        end
        else if (pick == 3)
        begin
            m.r00 = -fix_t'($urandom_range(0, ONE_Q));
            m.r11 = -fix_t'($urandom_range(0, ONE_Q));
            m.r22 = fix_t'($urandom_range(0, ONE_Q / 2));
        end
        return m;
    endfunction

    // expected quaternion store, filled at start, drained at done
    class quat_scoreboard;
        quat_t pending_q[$];
        int    n_errors;
        int    n_checked;
        int    branch_hits[4];

        function new();
            n_errors  = 0;
            n_checked = 0;
            foreach (branch_hits[i])
            begin
                branch_hits[i] = 0;
            end
        endfunction

        function void note_matrix(input matrix_t m);
            quat_t q;
            q = solve_quat(m);
            branch_hits[q.branch_taken]++;
            pending_q.insert(pending_q.size(), q);
        endfunction

        function void check_quat(input quat_t got);
            quat_t want;
            if (pending_q.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual %h", $realtime, got);
                n_errors++;
                return;
            end
            want = pending_q.pop_front();
            n_checked++;
            if (got.quat_w !== want.quat_w)
            begin
                $display("%0t: quat_w expected %0d actual %0d", $realtime, want.quat_w,
                         got.quat_w);
                n_errors++;
            end
            if (got.quat_x !== want.quat_x)
            begin
                $display("%0t: quat_x expected %0d actual %0d", $realtime, want.quat_x,
                         got.quat_x);
                n_errors++;
            end
            if (got.quat_y !== want.quat_y)
            begin
                $display("%0t: quat_y expected %0d actual %0d", $realtime, want.quat_y,
                         got.quat_y);
                n_errors++;
            end
            if (got.quat_z !== want.quat_z)
            begin
                $display("%0t: quat_z expected %0d actual %0d", $realtime, want.quat_z,
                         got.quat_z);
                n_errors++;
            end
            if (got.branch_taken !== want.branch_taken)
            begin
                $display("%0t: branch_taken expected %0d actual %0d", $realtime,
                         want.branch_taken, got.branch_taken);
                n_errors++;
            end
        endfunction
    endclass

    quat_scoreboard sb;

    // clock
    initial
    begin
        clk = 1'b0;
        forever
            #1 clk = ~clk;
    end

    // result checking
    always @(posedge clk)
    begin
        if (rst_n && done)
            sb.check_quat(result);
    end

    // present one word and wait until taken
    task automatic send_word(input matrix_t m);
        start  <= 1'b1;
        matrix <= m;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        sb.note_matrix(m);
    endtask

    // drop start for a number of cycles
    task automatic idle_cycles(input int n);
        start  <= 1'b0;
        matrix <= matrix_t'(MW'({$urandom, $urandom, $urandom, $urandom, $urandom}));
        repeat (n)
            @(posedge clk);
    endtask

    // directed matrices
    task automatic run_directed();
        matrix_t m;
        m = '0;
        m.r00 = ONE_F; m.r11 = ONE_F; m.r22 = ONE_F;
        send_word(m);                                   // identity
        m = '0;
        m.r00 = ONE_F; m.r11 = -ONE_F; m.r22 = -ONE_F;
        send_word(m);                                   // x half-turn
        m = '0;
        m.r00 = -ONE_F; m.r11 = ONE_F; m.r22 = -ONE_F;
        send_word(m);                                   // y half-turn
        m = '0;
        m.r00 = -ONE_F; m.r11 = -ONE_F; m.r22 = ONE_F;
        send_word(m);                                   // z half-turn
        m = '0;
        send_word(m);                                   // zero trace, ties go to z
        m = '0;
        m.r00 = fix_t'(5); m.r11 = fix_t'(5); m.r22 = fix_t'(-10);
        send_word(m);                                   // tie between x and y
        m = '0;
        m.r00 = -ONE_F; m.r11 = -ONE_F; m.r22 = -ONE_F;
        m.r01 = 16'sh7fff; m.r10 = 16'sh7fff;
        send_word(m);                                   // equal negative diagonal, big sums
        m = {9{16'sh8000}};
        send_word(m);                                   // all most negative
        m = {9{16'sh7fff}};
        send_word(m);                                   // all most positive
        m = {9{16'sh7fff}};
        m.r00 = 16'sh8000; m.r11 = 16'sh8000; m.r22 = 16'sh8001;
        send_word(m);                                   // large numerators, large root
        m = {9{16'sh8000}};
        m.r00 = fix_t'(1); m.r11 = '0; m.r22 = '0;
        send_word(m);                                   // smallest positive trace
        m = {9{16'sh7fff}};
        m.r00 = 16'sh8000; m.r11 = 16'sh8000; m.r22 = 16'sh8000;
        m.r12 = 16'sh8000; m.r21 = 16'sh8000;
        send_word(m);                                   // most negative r12 and r21, large numerators
        m = {9{16'sh5555}};
        send_word(m);
        m = {9{16'shaaaa}};
        send_word(m);
    endtask

    // stimulus
    initial
    begin
        int n_sent;
        int burst;
        sb     = new();
        rst_n  = 1'b0;
        start  = 1'b0;
        matrix = '0;
        repeat (11)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        run_directed();
        n_sent = 0;
        while (n_sent < N_RANDOM)
        begin
            burst = $urandom_range(1, 40);
            repeat (burst)
            begin
                send_word(rand_matrix());
                n_sent++;
            end
            if ($urandom_range(0, 2) != 0)
                idle_cycles($urandom_range(1, 12));
        end
        idle_cycles(1);
        while (sb.pending_q.size() != 0)
            @(posedge clk);
        repeat (LAT + 10)
            @(posedge clk);
        $display("checked %0d results: trace %0d, x %0d, y %0d, z %0d", sb.n_checked,
                 sb.branch_hits[0], sb.branch_hits[1], sb.branch_hits[2], sb.branch_hits[3]);
        if (sb.n_errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // timeout
    initial
    begin
        #200000;
        $display("timeout waiting for results");
        $display("Test completed with failures");
        $finish;
    end

endmodule
